[hdl/aspc_pkg.sv]
// ----------------------------------------------------------------------------
// aspc_pkg
// Shared types and constants for the aliquot sum / perfect number checker.
// ----------------------------------------------------------------------------
package aspc_pkg;

    // Width of the reported divisor sum; larger sums saturate.
    localparam int SUM_WIDTH = 35;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_CHECK,
        ST_ADD_CO,
        ST_DONE
    } aspc_state_t;

endpackage

[hdl/aspc_serial_div.sv]
// ----------------------------------------------------------------------------
// aspc_serial_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aspc_serial_div #(
    parameter int WIDTH     = 32,
    parameter int DIV_WIDTH = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [DIV_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [WIDTH-1:0]     quot,
    output logic [DIV_WIDTH-1:0] rem
);

    localparam int CW = $clog2(WIDTH + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [WIDTH-1:0]     acc_reg, acc_next;      // dividend out, quotient in
    logic [DIV_WIDTH-1:0] rem_reg, rem_next;
    logic [DIV_WIDTH-1:0] dsr_reg, dsr_next;

    logic [DIV_WIDTH:0]   trial;
    logic [DIV_WIDTH+1:0] diff;
    logic                 ge;

    assign trial = {rem_reg, acc_reg[WIDTH-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};
    assign ge    = ~diff[DIV_WIDTH+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH);
            acc_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
            acc_next = {acc_reg[WIDTH-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quot = acc_reg;
    assign rem  = rem_reg;

endmodule

[hdl/aliquot_sum_perfect_check_top.sv]
// ----------------------------------------------------------------------------
// aliquot_sum_perfect_check_top
// Sums the proper divisors of a number and flags perfect numbers.
// ----------------------------------------------------------------------------
// One number per transaction in, one result per transaction out. Trial
// divisors d = 2, 3, ... are tried while d <= number/d; each trial runs a
// bit-serial divider that produces one quotient bit per clock, and when a
// divisor with a distinct cofactor is found, a further step adds the
// cofactor. 0 and 1 skip the search and report a zero sum. The block works
// on one number at a time; the input is taken again as soon as the result
// has moved to the output register, even if that result has not yet been
// taken downstream. Sums that exceed the output width saturate to all ones
// and are never reported as perfect.
// ----------------------------------------------------------------------------
module aliquot_sum_perfect_check_top #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [NUM_WIDTH-1:0]           number,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [aspc_pkg::SUM_WIDTH-1:0] divisor_sum,
    output logic                           is_perfect
);

    import aspc_pkg::*;

    // Trial divisor never exceeds floor(sqrt(2^NUM_WIDTH - 1)) + 1.
    localparam int DW = (NUM_WIDTH + 1) / 2 + 1;
    // Adder width that holds any running sum plus any term.
    localparam int AW = ((NUM_WIDTH > SUM_WIDTH) ? NUM_WIDTH : SUM_WIDTH) + 1;
    localparam logic [AW-1:0] SUM_MAX_EXT = {{(AW - SUM_WIDTH){1'b0}}, {SUM_WIDTH{1'b1}}};

    aspc_state_t state_reg, state_next;

    logic [NUM_WIDTH-1:0] num_reg, num_next;
    logic [DW-1:0]        d_reg, d_next;
    logic [SUM_WIDTH-1:0] sum_reg, sum_next;
    logic                 over_reg, over_next;

    logic                 out_valid_reg, out_valid_next;
    logic [SUM_WIDTH-1:0] divisor_sum_reg;
    logic                 is_perfect_reg;
    logic                 out_load;

    logic                 div_start;
    logic                 div_done;
    logic [NUM_WIDTH-1:0] div_quot;
    logic [DW-1:0]        div_rem;

    logic [NUM_WIDTH-1:0] d_ext;
    logic [NUM_WIDTH-1:0] term;
    logic [AW-1:0]        sum_ext;
    logic                 sat_over;
    logic [SUM_WIDTH-1:0] sat_sum;
    logic                 perfect;

    aspc_serial_div #(
        .WIDTH     (NUM_WIDTH),
        .DIV_WIDTH (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Saturating accumulate: the term is the divisor itself, or the
    // cofactor (quotient) in the cofactor step.
    assign d_ext    = NUM_WIDTH'(d_reg);
    assign term     = (state_reg == ST_ADD_CO) ? div_quot : d_ext;
    assign sum_ext  = AW'(sum_reg) + AW'(term);
    assign sat_over = sum_ext > SUM_MAX_EXT;
    assign sat_sum  = sat_over ? {SUM_WIDTH{1'b1}} : sum_ext[SUM_WIDTH-1:0];

    assign perfect = (num_reg != '0) && !over_reg && (AW'(num_reg) == AW'(sum_reg));

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        d_next     = d_reg;
        sum_next   = sum_reg;
        over_next  = over_reg;
        in_stall   = 1'b1;
        div_start  = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    num_next  = number;
                    d_next    = DW'(2);
                    over_next = 1'b0;
                    if (number > NUM_WIDTH'(1))
                    begin
                        sum_next   = SUM_WIDTH'(1);   // divisor 1
                        state_next = ST_START;
                    end
                    else
                    begin
                        sum_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (d_ext > div_quot)
                    state_next = ST_DONE;          // d*d > n: search over
                else if (div_rem == '0)
                begin
                    sum_next  = sat_sum;
                    over_next = over_reg | sat_over;
                    if (div_quot != d_ext)
                        state_next = ST_ADD_CO;
                    else
                    begin
                        d_next     = d_reg + DW'(1);
                        state_next = ST_START;
                    end
                end
                else
                begin
                    d_next     = d_reg + DW'(1);
                    state_next = ST_START;
                end
            end
            ST_ADD_CO:
            begin
                sum_next   = sat_sum;
                over_next  = over_reg | sat_over;
                d_next     = d_reg + DW'(1);
                state_next = ST_START;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        d_reg    <= d_next;
        sum_reg  <= sum_next;
        over_reg <= over_next;
        if (out_load)
        begin
            divisor_sum_reg <= sum_reg;
            is_perfect_reg  <= perfect;
        end
    end

    assign out_valid   = out_valid_reg;
    assign divisor_sum = divisor_sum_reg;
    assign is_perfect  = is_perfect_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside a trial");

    a_cofactor_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD_CO |-> (div_rem == '0) && (div_quot != d_ext))
        else $error("cofactor added without an exact, distinct division");

    a_trial_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> d_reg >= DW'(2))
        else $error("trial divisor below two");

    a_take_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && in_valid |=> (state_reg == ST_START) || (state_reg == ST_DONE))
        else $error("accepted transaction did not start");

    a_perfect_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_perfect_reg |-> divisor_sum_reg >= SUM_WIDTH'(6))
        else $error("perfect flag on a sum below the smallest perfect number");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the aliquot sum / perfect number checker.
// ----------------------------------------------------------------------------
// Numbers are sent on the input channel one transaction at a time. A
// behavioral trial-division model predicts the divisor sum and the perfect
// flag of every accepted number. Every result transaction is checked
// against the oldest prediction. Both sides idle at random. One phase holds
// the output off long enough for the block to fill up. Most numbers are kept
// small, because the latency grows with the square root of the number.
// ----------------------------------------------------------------------------
module tb_top;

    import aspc_pkg::*;

    localparam int           NUM_W         = 32;
    localparam int           CLK_HALF      = 4;
    localparam int           SETTLE_CYCLES = 200;
    // The slowest number sent is all ones and the rest are small; this limit
    // allows several times the run of the whole stimulus.
    localparam longint       CYCLE_LIMIT   = 30_000_000;
    localparam int           REPORT_MAX    = 10;

    typedef struct {
        logic [NUM_W-1:0]     number;
        logic [SUM_WIDTH-1:0] sum;
        logic                 perfect;
    } aliquot_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [NUM_W-1:0]     number;
    logic                 out_valid;
    logic                 out_stall;
    logic [SUM_WIDTH-1:0] divisor_sum;
    logic                 is_perfect;

    // Predicted results, oldest first.
    aliquot_result_t pending[$];

    int     mismatches;
    longint cycle_count;
    bit     sender_idles;
    bit     receiver_idles;
    int     hold_left;

    aliquot_sum_perfect_check_top #(
        .NUM_WIDTH (NUM_W)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .number      (number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .divisor_sum (divisor_sum),
        .is_perfect  (is_perfect)
    );

    // ------------------------------------------------------------------------
    // Clock and cycle watchdog
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_WIDTH) - 1;

    // Adds one divisor to the sum, clamping at the widest reportable value.
    function automatic longint unsigned clamp_add(input longint unsigned acc,
                                                  input longint unsigned term,
                                                  inout bit clipped);
        if (term > SUM_LIMIT - acc)
        begin
            clipped = 1'b1;
            return SUM_LIMIT;
        end
        return acc + term;
    endfunction

    // Trial division: d runs from 2 while d <= n/d; each hit adds d and,
    // when different, its cofactor. 1 is a divisor of every n above 1.
    function automatic aliquot_result_t aliquot_of(input logic [NUM_W-1:0] value);
        aliquot_result_t   r;
        longint unsigned   n;
        longint unsigned   d;
        longint unsigned   acc;
        bit                clipped;
        n       = value;
        d       = 2;
        acc     = 0;
        clipped = 1'b0;
        if (n > 1)
        begin
            acc = 1;
            while (d <= n / d)
            begin
                if (n % d == 0)
                begin
                    acc = clamp_add(acc, d, clipped);
                    if (n / d != d)
                        acc = clamp_add(acc, n / d, clipped);
                end
                d = d + 1;
            end
        end
        r.number  = value;
        r.sum     = acc[SUM_WIDTH-1:0];
        r.perfect = (n != 0) && !clipped && (n == acc);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one number per transaction
    // ------------------------------------------------------------------------
    task automatic send_number(input logic [NUM_W-1:0] value);
        while (sender_idles && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending.push_back(aliquot_of(value));
    endtask

    // Sender pauses until every predicted result has been seen.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly small values, with some perfect numbers and squares mixed in.
    function automatic logic [NUM_W-1:0] pick_number();
        int unsigned kind;
        int unsigned root;
        int unsigned span;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            case ($urandom_range(3))
                0:       return 6;
                1:       return 28;
                2:       return 496;
                default: return 8128;
            endcase
        end
        if (kind < 18)
        begin
            root = $urandom_range(300, 1);
            return root * root;
        end
        span = $urandom_range(18);
        return $urandom & ((32'd1 << span) - 1);
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stall, plus a counted hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= receiver_idles && ($urandom_range(99) < 11);
    end

    task automatic note_mismatch(input string what, input longint unsigned num,
                                 input longint unsigned want,
                                 input longint unsigned got);
        mismatches = mismatches + 1;
        if (mismatches <= REPORT_MAX)
            $display("mismatch %s for number %0d: expected %0d, got %0d",
                     what, num, want, got);
    endtask

    // Every result transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin
        aliquot_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
                note_mismatch("unexpected result", 0, 0, divisor_sum);
            else
            begin
                want = pending.pop_front();
                if (divisor_sum !== want.sum)
                    note_mismatch("divisor_sum", want.number, want.sum, divisor_sum);
                if (is_perfect !== want.perfect)
                    note_mismatch("is_perfect", want.number, want.perfect, is_perfect);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero and one give a zero sum; 2 and 3 are primes; 4, 9, 25 are squares
    // where the cofactor equals the divisor and must not be added twice.
    task automatic test_small_values();
        send_number(0);
        send_number(1);
        send_number(2);
        send_number(3);
        send_number(4);
        send_number(9);
        send_number(25);
    endtask

    // Perfect numbers, with 28 flanked by neighbors on both sides that are not.
    task automatic test_perfect_numbers();
        send_number(6);
        send_number(27);
        send_number(28);
        send_number(29);
        send_number(496);
        send_number(8128);
        send_number(33550336);
    endtask

    // Larger squares, a large prime, abundant and odd abundant numbers.
    task automatic test_squares_and_primes();
        send_number(12);
        send_number(945);
        send_number(65536);
        send_number(65535);
        send_number(999983);
        send_number(1000000);
    endtask

    // All ones: the longest search and the largest value, every bit set.
    // With a 32-bit number the sum cannot reach the clamp.
    task automatic test_widest_value();
        send_number({NUM_W{1'b1}});
        wait_for_results();
    endtask

    task automatic test_random_numbers(input int count);
        repeat (count)
            send_number(pick_number());
    endtask

    // Back-to-back transactions with no idling on either side.
    task automatic test_burst_no_idle(input int count);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (count)
            send_number(pick_number());
        wait_for_results();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // Output held off for a long stretch while small numbers keep coming,
    // so the block fills and stalls its input.
    task automatic test_output_hold();
        hold_left = 1500;
        repeat (8)
            send_number($urandom_range(63));
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        number         = '0;
        out_stall      = 1'b0;
        mismatches     = 0;
        cycle_count    = 0;
        hold_left      = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_values();
        test_perfect_numbers();
        test_squares_and_primes();
        test_widest_value();
        test_random_numbers(40);
        wait_for_results();
        test_output_hold();
        test_burst_no_idle(20);
        test_random_numbers(30);

        wait_for_results();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[aliquot_sum_perfect_check_top.f]
hdl/aspc_pkg.sv
hdl/aspc_serial_div.sv
hdl/aliquot_sum_perfect_check_top.sv
tb/tb_top.sv
